// ----- rtl/sphere_light_frustum_cull_unit_assert.svh -----
// Assertion macros for the sphere light frustum cull unit.
// Included by the top level; no other dependencies.
`ifndef SPHERE_LIGHT_FRUSTUM_CULL_UNIT_ASSERT_SVH
`define SPHERE_LIGHT_FRUSTUM_CULL_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define SLFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define SLFC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/slfc_pkg.sv -----
// Shared types and constants for the sphere light frustum cull unit.
// No dependencies.
`default_nettype none
package slfc_pkg;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned SUM_W = 66;
  localparam int unsigned LEN_W = 33;

  typedef enum logic [2:0] {
    DEC_INSIDE = 3'd0,
    DEC_W_NONPOS = 3'd1,
    DEC_X_FAR = 3'd2,
    DEC_X_NEAR = 3'd3,
    DEC_Y_FAR = 3'd4,
    DEC_Y_NEAR = 3'd5,
    DEC_Z_FAR = 3'd6
  } decision_t;

  typedef enum logic [2:0] {
    REG_R0C01 = 3'd0, REG_R0C23 = 3'd1, REG_R1C01 = 3'd2, REG_R1C23 = 3'd3,
    REG_R2C01 = 3'd4, REG_R2C23 = 3'd5, REG_R3C01 = 3'd6, REG_R3C23 = 3'd7
  } reg_index_t;

  localparam logic [63:0] REG_RESET [NUM_REGS] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };
endpackage
`default_nettype wire

// ----- rtl/slfc_col_len.sv -----
// Column length unit: squared sum of a column's upper three entries and a
// restoring square root, recomputed after each configuration write. Uses slfc_pkg.
`default_nettype none
module slfc_col_len (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] m0,
  input  wire logic [31:0] m1,
  input  wire logic [31:0] m2,
  output logic [slfc_pkg::LEN_W-1:0] len
);
  localparam int unsigned SW = slfc_pkg::SUM_W;
  localparam int unsigned STEPS = SW / 2;

  logic [1:0] phase;
  logic [5:0] step;
  logic [63:0] sq;
  logic [SW-1:0] sum;
  logic [SW-1:0] op;
  logic [SW-1:0] res;
  logic [SW-1:0] one;
  logic [31:0] mag;
  logic [SW-1:0] trial;

  always_comb begin
    unique case (phase)
      2'd0: mag = m0[31] ? 32'(-m0) : m0;
      2'd1: mag = m1[31] ? 32'(-m1) : m1;
      default: mag = m2[31] ? 32'(-m2) : m2;
    endcase
    trial = res + one;
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      phase <= 2'd0;
      step <= '0;
      sum <= '0;
      sq <= '0;
      op <= '0;
      res <= '0;
      one <= '0;
      if (rst) len <= slfc_pkg::LEN_W'(64'h10000);
    end else if (phase != 2'd3) begin
      sq <= 64'(mag) * 64'(mag);
      if (step != 6'd0) sum <= sum + SW'(sq);
      step <= step + 6'd1;
      if (step == 6'd2) phase <= 2'd2;
      else if (step == 6'd1) phase <= 2'd2;
      else phase <= 2'd1;
      if (step == 6'd3) begin
        phase <= 2'd3;
        step <= '0;
        op <= sum + SW'(sq);
        res <= '0;
        one <= SW'(1) << (SW - 2);
      end
    end else if (step < 6'(STEPS)) begin
      if (op >= trial) begin
        op <= op - trial;
        res <= (res >> 1) + one;
      end else begin
        res <= res >> 1;
      end
      one <= one >> 2;
      step <= step + 6'd1;
      if (step == 6'(STEPS - 1)) len <= slfc_pkg::LEN_W'(
        (op >= trial) ? (res >> 1) + one : res >> 1);
    end
  end
endmodule
`default_nettype wire

// ----- rtl/slfc_pipe.sv -----
// Cull datapath: products, clip sums, scaled radii, compares and decision,
// across five register stages with stall. Uses slfc_pkg.
`default_nettype none
module slfc_pipe #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [63:0] regs [slfc_pkg::NUM_REGS],
  input  wire logic [slfc_pkg::LEN_W-1:0] len [3],
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] cx,
  input  wire logic [31:0] cy,
  input  wire logic [31:0] cz,
  input  wire logic [30:0] rad,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_dec
);
  localparam int unsigned CW = 66;

  logic [4:0] v;
  logic adv;
  assign adv = !v[4] || out_ready;
  assign in_ready = adv;
  assign out_valid = v[4];

  logic signed [31:0] m [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      m[r][0] = regs[2*r][31:0];
      m[r][1] = regs[2*r][63:32];
      m[r][2] = regs[2*r+1][31:0];
      m[r][3] = regs[2*r+1][63:32];
    end
  end

  // stage 1: products
  logic signed [63:0] p1 [3][4];
  logic [30:0] rad1;
  // stage 2: floored products
  logic signed [CW-1:0] f2 [3][4];
  logic [30:0] rad2;
  // stage 3: clip sums and scaled radii
  logic signed [CW-1:0] clip3 [4];
  logic [63:0] sc3 [3];
  // stage 4: compares
  logic wpos4;
  logic [4:0] fail4;
  logic [2:0] dec5;

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (adv) v <= {v[3:0], in_valid};
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        p1[0][c] <= $signed(cx) * m[0][c];
        p1[1][c] <= $signed(cy) * m[1][c];
        p1[2][c] <= $signed(cz) * m[2][c];
      end
      rad1 <= rad;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 4; c++)
          f2[r][c] <= CW'(p1[r][c] >>> FRAC_BITS);
      rad2 <= rad1;
      for (int c = 0; c < 4; c++)
        clip3[c] <= CW'(m[3][c]) + f2[0][c] + f2[1][c] + f2[2][c];
      for (int c = 0; c < 3; c++)
        sc3[c] <= (64'(rad2) * 64'(len[c])) >> FRAC_BITS;
      wpos4 <= clip3[3] > 0;
      fail4[0] <= clip3[0] - $signed(CW'(sc3[0])) > clip3[3];
      fail4[1] <= clip3[0] + $signed(CW'(sc3[0])) < -clip3[3];
      fail4[2] <= clip3[1] - $signed(CW'(sc3[1])) > clip3[3];
      fail4[3] <= clip3[1] + $signed(CW'(sc3[1])) < -clip3[3];
      fail4[4] <= clip3[2] - $signed(CW'(sc3[2])) > clip3[3];
      priority if (!wpos4) dec5 <= slfc_pkg::DEC_W_NONPOS;
      else if (fail4[0]) dec5 <= slfc_pkg::DEC_X_FAR;
      else if (fail4[1]) dec5 <= slfc_pkg::DEC_X_NEAR;
      else if (fail4[2]) dec5 <= slfc_pkg::DEC_Y_FAR;
      else if (fail4[3]) dec5 <= slfc_pkg::DEC_Y_NEAR;
      else if (fail4[4]) dec5 <= slfc_pkg::DEC_Z_FAR;
      else dec5 <= slfc_pkg::DEC_INSIDE;
    end
  end
  assign out_dec = dec5;
endmodule
`default_nettype wire

// ----- rtl/sphere_light_frustum_cull_unit.sv -----
// Sphere light frustum cull unit: top level with configuration registers.
// Depends on slfc_pkg, slfc_col_len, slfc_pipe and the assertion header.
// Takes one sphere beat per cycle unless m_tready stalls the pipeline; each
// result passes the five-stage product, floor, sum and scale, compare and select
// pipeline. After a matrix write three serial square-root units rebuild the
// column lengths; the user, not the block, must wait for that before sending spheres.
`default_nettype none
`include "sphere_light_frustum_cull_unit_assert.svh"
module sphere_light_frustum_cull_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // center_x, center_y, center_z, radius, zero pad
  input  wire logic [127:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // visible, decision, zero pad
  output logic [7:0]        m_tdata
);
  logic [63:0] regs [slfc_pkg::NUM_REGS];
  logic [slfc_pkg::LEN_W-1:0] len [3];
  logic [2:0] dec;

  always_ff @(posedge clk) begin
    if (rst) regs <= slfc_pkg::REG_RESET;
    else if (cfg_we) regs[cfg_index] <= cfg_data;
  end

  for (genvar c = 0; c < 3; c++) begin : g_len
    slfc_col_len u_len (
      .clk(clk), .rst(rst), .start(cfg_we),
      .m0(regs[c/2][32*(c%2) +: 32]),
      .m1(regs[2+c/2][32*(c%2) +: 32]),
      .m2(regs[4+c/2][32*(c%2) +: 32]),
      .len(len[c])
    );
  end

  slfc_pipe #(.FRAC_BITS(FRAC_BITS)) u_pipe (
    .clk(clk), .rst(rst), .regs(regs), .len(len),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .cx(s_tdata[31:0]), .cy(s_tdata[63:32]), .cz(s_tdata[95:64]),
    .rad(s_tdata[126:96]),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_dec(dec)
  );

  assign m_tdata = {4'd0, dec, (dec == slfc_pkg::DEC_INSIDE) || (dec == slfc_pkg::DEC_W_NONPOS)};

  `SLFC_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `SLFC_ASSERT_NOW(a_vis, clk, rst, m_tvalid, m_tdata[0] == (m_tdata[3:1] <= 3'd1))
endmodule
`default_nettype wire
